// ===== design/atmosphere_table_interpolator_assert.svh =====
// Assertion macros for the atmosphere table interpolator.
`ifndef ATMOSPHERE_TABLE_INTERPOLATOR_ASSERT_SVH
`define ATMOSPHERE_TABLE_INTERPOLATOR_ASSERT_SVH

// same-cycle implication
`define ATI_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("atmti assertion failed");

// next-cycle implication
`define ATI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("atmti assertion failed");

`endif

// ===== design/atmti_pkg.sv =====
// Shared types and constants of the atmosphere table interpolator.
`default_nettype none
package atmti_pkg;

  localparam int DEPTH  = 4096;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [23:0] ALT_MAX = 24'd16000000;
  localparam logic [35:0] VISC_MAX = '1;
  localparam logic [26:0] SOUND_MAX = '1;

  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_LOAD  = 1'b1;

  localparam logic [2:0] REG_HEAT_RATIO       = 3'd0;
  localparam logic [2:0] REG_GAS_CONSTANT     = 3'd1;
  localparam logic [2:0] REG_SUTHERLAND_TEMP  = 3'd2;
  localparam logic [2:0] REG_SUTHERLAND_COEFF = 3'd3;
  localparam logic [2:0] REG_ENTRIES_USED     = 3'd4;

  typedef enum logic [3:0] {
    STEP_LERP_MUL0, STEP_LERP_DIV0,
    STEP_LERP_MUL1, STEP_LERP_DIV1,
    STEP_LERP_MUL2, STEP_LERP_DIV2,
    STEP_VIS_ROOT, STEP_VIS_MUL, STEP_VIS_DIV, STEP_VIS_BETA,
    STEP_SND_GR, STEP_SND_GH, STEP_SND_GL, STEP_SND_ROOT
  } step_t;

  typedef struct packed {
    logic [17:0] heat_ratio;
    logic [25:0] gas_constant;
    logic [23:0] sutherland_temp;
    logic [31:0] sutherland_coeff;
    logic [12:0] entries_used;
  } cfg_t;

  typedef struct packed {
    logic  load_we;
    logic  accept_query;
    logic  cmp;
    logic  q_inc;
    logic  addr_lo;
    logic  cap_lo;
    logic  take_hi;
    logic  start;
    logic  commit;
    step_t step;
    logic  emit;
  } cmd_t;

  typedef struct packed {
    logic more;
    logic exact;
    logic busy;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== design/atmti_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module atmti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/atmti_ctrl.sv =====
// Controller: item acceptance, table scan and arithmetic step sequencing.
`default_nettype none
module atmti_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              opcode,
  input  wire atmti_pkg::sts_t   sts,
  output atmti_pkg::cmd_t        cmd
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_RD    = 8'b0000_0010,
    ST_CMP   = 8'b0000_0100,
    ST_LORD  = 8'b0000_1000,
    ST_LOCAP = 8'b0001_0000,
    ST_GO    = 8'b0010_0000,
    ST_WAIT  = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  atmti_pkg::step_t step, step_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    cmd.step   = step;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (opcode == atmti_pkg::OP_LOAD) begin
            cmd.load_we = 1'b1;
          end else begin
            cmd.accept_query = 1'b1;
            state_next = ST_RD;
          end
        end
      end
      ST_RD: state_next = ST_CMP;
      ST_CMP: begin
        cmd.cmp = 1'b1;
        if (sts.more) begin
          cmd.q_inc = 1'b1;
          state_next = ST_RD;
        end else if (sts.exact) begin
          cmd.take_hi = 1'b1;
          step_next = atmti_pkg::STEP_VIS_ROOT;
          state_next = ST_GO;
        end else begin
          state_next = ST_LORD;
        end
      end
      ST_LORD: begin
        cmd.addr_lo = 1'b1;
        state_next = ST_LOCAP;
      end
      ST_LOCAP: begin
        cmd.cap_lo = 1'b1;
        step_next = atmti_pkg::STEP_LERP_MUL0;
        state_next = ST_GO;
      end
      ST_GO: begin
        cmd.start = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (!sts.busy) begin
          cmd.commit = 1'b1;
          if (step == atmti_pkg::STEP_SND_ROOT) begin
            state_next = ST_EMIT;
          end else begin
            step_next = atmti_pkg::step_t'(step + 4'd1);
            state_next = ST_GO;
          end
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= atmti_pkg::STEP_LERP_MUL0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/atmti_dp.sv =====
// Datapath: table memories, scan registers, shared serial arithmetic unit, result register.
`default_nettype none
module atmti_dp (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire atmti_pkg::cmd_t                cmd,
  output atmti_pkg::sts_t                     sts,
  input  wire atmti_pkg::cfg_t                cfg,
  input  wire logic        [11:0]             row_index,
  input  wire logic signed [24:0]             altitude,
  input  wire logic        [21:0]             row_temperature,
  input  wire logic        [48:0]             row_pressure,
  input  wire logic        [56:0]             row_density,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic             [21:0]             temperature,
  output logic             [48:0]             pressure,
  output logic             [56:0]             density,
  output logic             [35:0]             viscosity,
  output logic             [26:0]             sound_speed,
  output logic                                status
);

  localparam int AW = atmti_pkg::ADDR_W;

  typedef enum logic [1:0] {U_MUL, U_DIV, U_SQRT} unit_t;

  // altitude clamp
  logic [23:0] h_in;
  logic        h_clamped;
  always_comb begin
    if (altitude[24]) begin
      h_in = '0;
      h_clamped = 1'b1;
    end else if (altitude[23:0] > atmti_pkg::ALT_MAX) begin
      h_in = atmti_pkg::ALT_MAX;
      h_clamped = 1'b1;
    end else begin
      h_in = altitude[23:0];
      h_clamped = 1'b0;
    end
  end

  // table memories
  logic          we;
  logic [AW-1:0] waddr, raddr, q, last_q;
  logic [23:0]   rd_a;
  logic [21:0]   rd_t;
  logic [48:0]   rd_p;
  logic [56:0]   rd_d;

  assign we    = cmd.load_we && (32'(row_index) < 32'(atmti_pkg::DEPTH));
  assign waddr = AW'(row_index);
  assign raddr = cmd.addr_lo ? q - AW'(1) : q;

  atmti_ram #(.WIDTH(24), .DEPTH(atmti_pkg::DEPTH)) u_alt (
    .clk(clk), .we(we), .waddr(waddr), .wdata(h_in), .raddr(raddr), .rdata(rd_a));
  atmti_ram #(.WIDTH(22), .DEPTH(atmti_pkg::DEPTH)) u_tmp (
    .clk(clk), .we(we), .waddr(waddr), .wdata(row_temperature), .raddr(raddr),
    .rdata(rd_t));
  atmti_ram #(.WIDTH(49), .DEPTH(atmti_pkg::DEPTH)) u_prs (
    .clk(clk), .we(we), .waddr(waddr), .wdata(row_pressure), .raddr(raddr),
    .rdata(rd_p));
  atmti_ram #(.WIDTH(57), .DEPTH(atmti_pkg::DEPTH)) u_den (
    .clk(clk), .we(we), .waddr(waddr), .wdata(row_density), .raddr(raddr),
    .rdata(rd_d));

  always_comb begin
    if (cfg.entries_used < 13'd2) begin
      last_q = AW'(1);
    end else if (32'(cfg.entries_used) > 32'(atmti_pkg::DEPTH)) begin
      last_q = AW'(atmti_pkg::DEPTH - 1);
    end else begin
      last_q = AW'(cfg.entries_used - 13'd1);
    end
  end

  logic [23:0] h, hi_a, d_off, den;
  logic        clamped;
  logic [21:0] hi_t, lo_t, res_t, gl;
  logic [48:0] hi_p, lo_p, res_p;
  logic [56:0] hi_d, lo_d, res_d;
  logic [43:0] p1;
  logic [35:0] mu;
  logic [26:0] ss;

  assign sts.more  = (rd_a < h) && (q != last_q);
  assign sts.exact = (rd_a < h) || (q == '0) || (rd_a == h);

  // lerp differences
  logic        neg_t, neg_p, neg_d;
  logic [21:0] diff_t;
  logic [48:0] diff_p;
  logic [56:0] diff_d;
  assign neg_t  = hi_t < lo_t;
  assign neg_p  = hi_p < lo_p;
  assign neg_d  = hi_d < lo_d;
  assign diff_t = neg_t ? lo_t - hi_t : hi_t - lo_t;
  assign diff_p = neg_p ? lo_p - hi_p : hi_p - lo_p;
  assign diff_d = neg_d ? lo_d - hi_d : hi_d - lo_d;

  // serial arithmetic unit
  logic [89:0] eng_acc;
  logic [57:0] eng_a;
  logic [31:0] eng_b;
  logic [33:0] eng_rem;
  logic [28:0] eng_div;
  logic [6:0]  eng_cnt;
  logic        busy;
  unit_t       eng_unit;

  logic [27:0] t16;
  logic [28:0] vsum;
  logic [56:0] grt;
  assign t16  = {res_t, 6'b0};
  assign vsum = 29'(t16) + 29'(cfg.sutherland_temp);
  assign grt  = 57'({p1, 12'b0}) + 57'(eng_acc[43:10]);

  unit_t       op_unit;
  logic [57:0] op_a;
  logic [31:0] op_b;
  logic [80:0] op_num;
  logic [28:0] op_den;
  logic [63:0] op_src;

  always_comb begin
    op_unit = U_MUL;
    op_a    = '0;
    op_b    = '0;
    op_num  = '0;
    op_den  = '0;
    op_src  = '0;
    unique case (cmd.step)
      atmti_pkg::STEP_LERP_MUL0: begin op_a = 58'(diff_t); op_b = 32'(d_off); end
      atmti_pkg::STEP_LERP_MUL1: begin op_a = 58'(diff_p); op_b = 32'(d_off); end
      atmti_pkg::STEP_LERP_MUL2: begin op_a = 58'(diff_d); op_b = 32'(d_off); end
      atmti_pkg::STEP_LERP_DIV0, atmti_pkg::STEP_LERP_DIV1,
      atmti_pkg::STEP_LERP_DIV2: begin
        op_unit = U_DIV;
        op_num  = eng_acc[80:0];
        op_den  = 29'(den);
      end
      atmti_pkg::STEP_VIS_ROOT: begin
        op_unit = U_SQRT;
        op_src  = 64'({t16, 16'b0});
      end
      atmti_pkg::STEP_VIS_MUL: begin op_a = 58'(t16); op_b = eng_b; end
      atmti_pkg::STEP_VIS_DIV: begin
        op_unit = U_DIV;
        op_num  = 81'({eng_acc[49:0], 8'b0});
        op_den  = vsum;
      end
      atmti_pkg::STEP_VIS_BETA: begin
        op_a = eng_acc[57:0];
        op_b = cfg.sutherland_coeff;
      end
      atmti_pkg::STEP_SND_GR: begin
        op_a = 58'(cfg.gas_constant);
        op_b = 32'(cfg.heat_ratio);
      end
      atmti_pkg::STEP_SND_GH: begin op_a = 58'(eng_acc[43:22]); op_b = 32'(res_t); end
      atmti_pkg::STEP_SND_GL: begin op_a = 58'(gl); op_b = 32'(res_t); end
      atmti_pkg::STEP_SND_ROOT: begin
        op_unit = U_SQRT;
        op_src  = 64'(grt);
      end
      default: op_unit = U_MUL;
    endcase
  end

  logic [89:0] mul_sum;
  logic [29:0] div_sh, div_dif;
  logic        div_ge;
  logic [35:0] sq_sh, sq_trial, sq_dif;
  logic        sq_ge;

  assign mul_sum  = {eng_acc[88:0], 1'b0} + (eng_b[31] ? 90'(eng_a) : 90'd0);
  assign div_sh   = {eng_rem[28:0], eng_acc[80]};
  assign div_ge   = div_sh >= {1'b0, eng_div};
  assign div_dif  = div_sh - {1'b0, eng_div};
  assign sq_sh    = {eng_rem, eng_acc[63:62]};
  assign sq_trial = {2'b0, eng_b, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;
  assign sq_dif   = sq_sh - sq_trial;

  assign sts.busy = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.start) begin
      busy     <= 1'b1;
      eng_unit <= op_unit;
      eng_rem  <= '0;
      unique case (op_unit)
        U_MUL: begin
          eng_acc <= '0;
          eng_a   <= op_a;
          eng_b   <= op_b;
          eng_cnt <= 7'd31;
        end
        U_DIV: begin
          eng_acc <= 90'(op_num);
          eng_div <= op_den;
          eng_cnt <= 7'd80;
        end
        U_SQRT: begin
          eng_acc <= 90'(op_src);
          eng_b   <= '0;
          eng_cnt <= 7'd31;
        end
        default: eng_cnt <= '0;
      endcase
    end else if (busy) begin
      unique case (eng_unit)
        U_MUL: begin
          eng_acc <= mul_sum;
          eng_b   <= {eng_b[30:0], 1'b0};
        end
        U_DIV: begin
          eng_rem <= 34'(div_ge ? div_dif[28:0] : div_sh[28:0]);
          eng_acc <= {9'b0, eng_acc[79:0], div_ge};
        end
        U_SQRT: begin
          eng_rem <= sq_ge ? sq_dif[33:0] : sq_sh[33:0];
          eng_b   <= {eng_b[30:0], sq_ge};
          eng_acc <= {eng_acc[87:0], 2'b0};
        end
        default: eng_acc <= eng_acc;
      endcase
      if (eng_cnt == '0) begin
        busy <= 1'b0;
      end else begin
        eng_cnt <= eng_cnt - 7'd1;
      end
    end
  end

  // scan and result registers
  always_ff @(posedge clk) begin
    if (cmd.accept_query) begin
      h       <= h_in;
      clamped <= h_clamped;
      q       <= '0;
    end
    if (cmd.cmp) begin
      hi_a <= rd_a;
      hi_t <= rd_t;
      hi_p <= rd_p;
      hi_d <= rd_d;
    end
    if (cmd.q_inc) begin
      q <= q + AW'(1);
    end
    if (cmd.take_hi) begin
      res_t <= rd_t;
      res_p <= rd_p;
      res_d <= rd_d;
    end
    if (cmd.cap_lo) begin
      lo_t  <= rd_t;
      lo_p  <= rd_p;
      lo_d  <= rd_d;
      d_off <= h - rd_a;
      den   <= hi_a - rd_a;
    end
    if (cmd.commit) begin
      unique case (cmd.step)
        atmti_pkg::STEP_LERP_DIV0:
          res_t <= neg_t ? lo_t - eng_acc[21:0] : lo_t + eng_acc[21:0];
        atmti_pkg::STEP_LERP_DIV1:
          res_p <= neg_p ? lo_p - eng_acc[48:0] : lo_p + eng_acc[48:0];
        atmti_pkg::STEP_LERP_DIV2:
          res_d <= neg_d ? lo_d - eng_acc[56:0] : lo_d + eng_acc[56:0];
        atmti_pkg::STEP_VIS_BETA: begin
          if (vsum == '0) begin
            mu <= '0;
          end else if (|eng_acc[89:60]) begin
            mu <= atmti_pkg::VISC_MAX;
          end else begin
            mu <= eng_acc[59:24];
          end
        end
        atmti_pkg::STEP_SND_GR: gl <= eng_acc[21:0];
        atmti_pkg::STEP_SND_GH: p1 <= eng_acc[43:0];
        atmti_pkg::STEP_SND_ROOT:
          ss <= (|eng_b[31:27]) ? atmti_pkg::SOUND_MAX : eng_b[26:0];
        default: gl <= gl;
      endcase
    end
  end

  // output register
  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      temperature <= res_t;
      pressure    <= res_p;
      density     <= res_d;
      viscosity   <= mu;
      sound_speed <= ss;
      status      <= clamped;
    end
  end

endmodule
`default_nettype wire

// ===== design/atmosphere_table_interpolator.sv =====
// Top level: configuration registers, controller and datapath of the atmosphere table interpolator.
// Load item: written to the table while idle, ready for the next item in the following cycle.
// Query item: a read state and a compare state per table row scanned, then the result steps on an exact or end row,
// or the interpolation and result steps otherwise; one shared bit-serial multiply/divide/root unit runs each step.
// A finished result waits in the output register while the next item is taken.
// Synchronous reset clears control and loads default values into the configuration registers; table rows are
// undefined until loaded and there is no clearing pass.
`default_nettype none
module atmosphere_table_interpolator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        opcode,
  input  wire logic [11:0] row_index,
  input  wire logic signed [24:0] altitude,
  input  wire logic [21:0] row_temperature,
  input  wire logic [48:0] row_pressure,
  input  wire logic [56:0] row_density,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [21:0] temperature,
  output logic      [48:0] pressure,
  output logic      [56:0] density,
  output logic      [35:0] viscosity,
  output logic      [26:0] sound_speed,
  output logic             status
);

  atmti_pkg::cfg_t cfg;
  atmti_pkg::cmd_t cmd;
  atmti_pkg::sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heat_ratio       <= 18'd91750;
      cfg.gas_constant     <= 26'd18812109;
      cfg.sutherland_temp  <= 24'd7235174;
      cfg.sutherland_coeff <= 32'd410390517;
      cfg.entries_used     <= 13'd4096;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        atmti_pkg::REG_HEAT_RATIO:       cfg.heat_ratio       <= pwdata[17:0];
        atmti_pkg::REG_GAS_CONSTANT:     cfg.gas_constant     <= pwdata[25:0];
        atmti_pkg::REG_SUTHERLAND_TEMP:  cfg.sutherland_temp  <= pwdata[23:0];
        atmti_pkg::REG_SUTHERLAND_COEFF: cfg.sutherland_coeff <= pwdata;
        atmti_pkg::REG_ENTRIES_USED:     cfg.entries_used     <= pwdata[12:0];
        default: cfg <= cfg;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      atmti_pkg::REG_HEAT_RATIO:       prdata = 32'(cfg.heat_ratio);
      atmti_pkg::REG_GAS_CONSTANT:     prdata = 32'(cfg.gas_constant);
      atmti_pkg::REG_SUTHERLAND_TEMP:  prdata = 32'(cfg.sutherland_temp);
      atmti_pkg::REG_SUTHERLAND_COEFF: prdata = cfg.sutherland_coeff;
      atmti_pkg::REG_ENTRIES_USED:     prdata = 32'(cfg.entries_used);
      default:                         prdata = '0;
    endcase
  end

  atmti_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .sts(sts), .cmd(cmd));

  atmti_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .cfg(cfg),
    .row_index(row_index), .altitude(altitude), .row_temperature(row_temperature),
    .row_pressure(row_pressure), .row_density(row_density),
    .out_valid(out_valid), .out_stall(out_stall),
    .temperature(temperature), .pressure(pressure), .density(density),
    .viscosity(viscosity), .sound_speed(sound_speed), .status(status));

`include "atmosphere_table_interpolator_assert.svh"

  `ATI_ASSERT_NEXT(a_query_holds_input,
    in_valid && !in_stall && (opcode == atmti_pkg::OP_QUERY), in_stall)
  `ATI_ASSERT_SAME(a_cold_is_silent, out_valid && (temperature == 22'd0),
    sound_speed == 27'd0)
  `ATI_ASSERT_SAME(a_result_from_busy, $rose(out_valid), $past(in_stall))

endmodule
`default_nettype wire
